// ===== hw/rtl/mtbr_pkg.sv =====
package mtbr_pkg;

    localparam int unsigned StateWords   = 624;
    localparam int unsigned MiddleOffset = 397;
    localparam int unsigned AddrW        = 10;

    localparam logic [31:0] InitMult    = 32'd1812433253;
    localparam logic [31:0] TwistMatrix = 32'd2567483615;
    localparam logic [31:0] TemperB     = 32'd2636928640;
    localparam logic [31:0] TemperC     = 32'd4022730752;
    localparam logic [31:0] DefaultSeed = 32'd5489;

    localparam logic [AddrW-1:0] LastAddr   = AddrW'(StateWords - 1);
    localparam logic [AddrW-1:0] MiddleAddr = AddrW'(MiddleOffset);

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef logic [AddrW-1:0] t_addr;

    typedef struct packed {
        logic        opcode;
        logic [31:0] seed_value;
        logic [31:0] bound;
    } t_req;

    typedef struct packed {
        logic [31:0] random_value;
    } t_rsp;

    // wrap-around increment over the state ring
    function automatic t_addr addr_inc(input t_addr a);
        addr_inc = (a == LastAddr) ? '0 : a + t_addr'(1);
    endfunction

    // output tempering of one state word
    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        temper = y;
    endfunction

endpackage

// ===== hw/rtl/mtbr_req_if.sv =====
interface mtbr_req_if;
    import mtbr_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtbr_rsp_if.sv =====
interface mtbr_rsp_if;
    import mtbr_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/mtbr_ram.sv =====
module mtbr_ram #(
    parameter int Width = 32,
    parameter int Depth = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/mtbr_divider.sv =====
module mtbr_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    // restoring remainder, one dividend bit per cycle
    logic [32:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] trial;

    always_comb begin
        trial = {r_rem, r_num[32]} - {2'b00, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[31:0], 1'b0};
                r_rem <= trial[33] ? {r_rem[31:0], r_num[32]} : trial[32:0];
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[31:0];

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("divider done while busy");
endmodule

// ===== hw/rtl/mt19937_bounded_random.sv =====
// Seed transaction: busy after acceptance, writing one state word a cycle, no result.
// Raw draw (bound 0): every 624th word first twists the whole state, word by word through
// S_TW_W, S_TW_A, S_TW_B and S_TW_C; a draw before any seed first seeds from the seed register.
// Bounded draw: two 33-step remainders (limit, then result); a rejected word is replaced by the
// next word. One transaction at a time: the next is accepted once idle and the result is taken.
// Synchronous active-low reset: not seeded, read position 0, seed register 5489.
module mt19937_bounded_random (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [31:0]             i_cfg_wdata,
    mtbr_req_if.sink                i_req,
    mtbr_rsp_if.source              o_rsp
);
    import mtbr_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEED  = 4'd1;
    localparam logic [3:0] S_TW_A  = 4'd2;
    localparam logic [3:0] S_TW_B  = 4'd3;
    localparam logic [3:0] S_TW_C  = 4'd4;
    localparam logic [3:0] S_TW_W  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_RD_W  = 4'd7;
    localparam logic [3:0] S_LIM   = 4'd8;
    localparam logic [3:0] S_CHK   = 4'd9;
    localparam logic [3:0] S_MOD   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;
    localparam logic [3:0] S_FIRST = 4'd12;

    logic [3:0]  r_state;
    logic [31:0] r_cfg_seed;
    logic        r_seeded;
    t_addr       r_pos;
    t_addr       r_k;
    logic [31:0] r_prev;
    logic        r_draw;
    logic [31:0] r_bound;
    logic [31:0] r_limit;
    logic        r_lim_ok;
    logic        r_div_run;
    logic [31:0] r_word;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_out;
    logic        r_out_v;

    // state memory port signals
    logic        we;
    t_addr       waddr;
    logic [31:0] wdata;
    t_addr       raddr;
    logic [31:0] rdata;

    mtbr_ram #(.Width(32), .Depth(StateWords)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // shared remainder unit
    logic        div_start;
    logic [32:0] div_num;
    logic        div_done;
    logic [31:0] div_rem;

    mtbr_divider u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_num),
        .i_divisor (r_bound),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    logic [31:0] seed_next;
    logic [31:0] y_mix;
    logic [31:0] tw_val;

    always_comb begin
        seed_next = InitMult * (r_prev ^ (r_prev >> 30)) + 32'(r_k);
        y_mix     = {r_a[31], r_b[30:0]};
        tw_val    = rdata ^ (y_mix >> 1) ^ (y_mix[0] ? TwistMatrix : 32'd0);
    end

    // memory address, write and remainder start selection per sequencer step
    always_comb begin
        we    = 1'b0;
        waddr = r_k;
        wdata = seed_next;
        raddr = r_k;
        div_start = 1'b0;
        div_num   = {1'b1, 32'd0};
        case (r_state)
            S_SEED: begin
                we = 1'b1;
            end
            S_FIRST: begin
                we    = 1'b1;
                waddr = '0;
                wdata = r_prev;
            end
            S_TW_A: raddr = addr_inc(r_k);
            S_TW_B: begin
                raddr = (r_k >= t_addr'(StateWords - MiddleOffset))
                      ? r_k - t_addr'(StateWords - MiddleOffset)
                      : r_k + MiddleAddr;
            end
            S_TW_C: begin
                we    = 1'b1;
                wdata = tw_val;
            end
            S_RD: raddr = r_pos;
            // start the limit remainder once, then wait for it
            S_LIM: div_start = !r_lim_ok && !r_div_run && (r_bound != 32'd0);
            S_CHK: begin
                div_start = (r_bound != 32'd0) && (r_word <= r_limit);
                div_num   = {1'b0, r_word};
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_out_v;
    assign o_rsp.valid = r_out_v;
    assign o_rsp.data.random_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_seed <= DefaultSeed;
            r_seeded   <= 1'b0;
            r_pos      <= '0;
            r_out_v    <= 1'b0;
            r_k        <= '0;
            r_lim_ok   <= 1'b0;
            r_div_run  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_seed <= i_cfg_wdata;
            end
            if (o_rsp.valid && o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
            // remainder unit in use
            if (div_start) begin
                r_div_run <= 1'b1;
            end else if (div_done) begin
                r_div_run <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_bound  <= i_req.data.bound;
                        r_lim_ok <= 1'b0;
                        r_draw   <= (i_req.data.opcode == OP_DRAW);
                        if (i_req.data.opcode == OP_SEED) begin
                            r_prev  <= i_req.data.seed_value;
                            r_state <= S_FIRST;
                        end else if (!r_seeded) begin
                            r_prev  <= r_cfg_seed;
                            r_state <= S_FIRST;
                        end else begin
                            r_state <= S_LIM;
                        end
                    end
                end
                S_FIRST: begin
                    r_k     <= t_addr'(1);
                    r_state <= S_SEED;
                end
                S_SEED: begin
                    r_prev <= seed_next;
                    r_k    <= addr_inc(r_k);
                    if (r_k == LastAddr) begin
                        r_seeded <= 1'b1;
                        r_pos    <= '0;
                        r_state  <= r_draw ? S_LIM : S_IDLE;
                    end
                end
                S_LIM: begin
                    if (r_lim_ok || r_bound == 32'd0) begin
                        r_lim_ok <= 1'b1;
                        r_k      <= '0;
                        r_state  <= (r_pos == '0) ? S_TW_W : S_RD;
                    end else if (div_done) begin
                        r_limit  <= 32'hFFFF_FFFF - div_rem;
                        r_lim_ok <= 1'b1;
                    end
                end
                S_TW_W: begin
                    // read word k, registered next cycle
                    r_state <= S_TW_A;
                end
                S_TW_A: begin
                    r_a     <= rdata;
                    r_state <= S_TW_B;
                end
                S_TW_B: begin
                    r_b     <= rdata;
                    r_state <= S_TW_C;
                end
                S_TW_C: begin
                    r_k <= addr_inc(r_k);
                    r_state <= (r_k == LastAddr) ? S_RD : S_TW_W;
                end
                S_RD: begin
                    r_state <= S_RD_W;
                end
                S_RD_W: begin
                    r_word  <= temper(rdata);
                    r_pos   <= addr_inc(r_pos);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_bound == 32'd0) begin
                        r_out   <= r_word;
                        r_state <= S_OUT;
                    end else if (r_word > r_limit) begin
                        r_state <= S_LIM;
                    end else begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (div_done) begin
                        r_out   <= div_rem;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LastAddr) else $error("read position out of range");
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_v) else $error("result not raised");
    a_seeded_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> r_seeded) else $error("draw from unseeded state");
endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mtbr_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    mtbr_req_if req_ch ();
    mtbr_rsp_if rsp_ch ();

    mt19937_bounded_random uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0] mt_words [StateWords];
    int unsigned mt_pos;
    bit          mt_seeded;
    logic [31:0] seed_reg;

    logic [31:0] expected_values [$];
    int unsigned mismatches;
    int unsigned values_checked;
    int unsigned draws_sent;
    int unsigned seeds_sent;
    int unsigned idle_cycles;
    bit          timed_out;
    bit          rsp_stall_on;
    int unsigned rsp_wait = 0;

    // initialisation recurrence
    function automatic void mt_seed(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int k = 1; k < StateWords; k++) begin
            p = mt_words[k-1];
            mt_words[k] = InitMult * (p ^ (p >> 30)) + 32'(k);
        end
        mt_pos = 0;
        mt_seeded = 1'b1;
    endfunction

    // regenerate the whole ring
    function automatic void mt_twist();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < StateWords; k++) begin
            y = (mt_words[k] & 32'h8000_0000)
              | (mt_words[(k + 1) % StateWords] & 32'h7fff_ffff);
            v = mt_words[(k + MiddleOffset) % StateWords] ^ (y >> 1);
            if (y[0]) v = v ^ TwistMatrix;
            mt_words[k] = v;
        end
    endfunction

    function automatic logic [31:0] mt_next();
        logic [31:0] y;
        if (!mt_seeded) mt_seed(seed_reg);
        if (mt_pos == 0) mt_twist();
        y = mt_words[mt_pos];
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        mt_pos = (mt_pos + 1) % StateWords;
        return y;
    endfunction

    function automatic logic [31:0] bounded_draw(input logic [31:0] bnd);
        logic [31:0] w;
        logic [31:0] lim;
        if (bnd == 0) return mt_next();
        lim = 32'hffff_ffff - 32'(64'h1_0000_0000 % {32'd0, bnd});
        do w = mt_next(); while (w > lim);
        return w % bnd;
    endfunction

    // send one transaction and predict its outcome
    task automatic send_item(input logic op, input logic [31:0] sv, input logic [31:0] bnd);
        int unsigned gap;
        t_req r;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        r.opcode = op;
        r.seed_value = sv;
        r.bound = bnd;
        req_ch.data <= r;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (op == OP_SEED) begin
            mt_seed(sv);
            seeds_sent++;
        end else begin
            expected_values.push_back(bounded_draw(bnd));
            draws_sent++;
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_values.size() != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
    endtask

    task automatic write_seed_reg(input logic [31:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        seed_reg = v;
    endtask

    // response side: random stall per transaction, sometimes none
    always @(negedge i_clk) begin
        if (!rsp_stall_on) rsp_ch.ready <= 1'b1;
        else if (rsp_ch.valid && !rsp_ch.ready) begin
            if (rsp_wait == 0) rsp_ch.ready <= 1'b1;
            else rsp_wait <= rsp_wait - 1;
        end else begin
            rsp_ch.ready <= 1'b0;
            rsp_wait <= $urandom_range(0, 18);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", rsp_ch.data.random_value);
            end else begin
                logic [31:0] e;
                e = expected_values.pop_front();
                values_checked++;
                if (e !== rsp_ch.data.random_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("random_value mismatch: expected %h got %h",
                                 e, rsp_ch.data.random_value);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 200000) begin
                $display("watchdog expired");
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic test_default_seed();
        // draws before any seed use the reset register value
        send_item(OP_DRAW, '0, 32'd0);
        send_item(OP_DRAW, 32'hffff_ffff, 32'd0);
        send_item(OP_DRAW, '0, 32'd1);
        wait_drained();
    endtask

    task automatic test_directed();
        send_item(OP_SEED, 32'd0, 32'hffff_ffff);
        send_item(OP_DRAW, '0, 32'hffff_ffff);
        send_item(OP_DRAW, '0, 32'h8000_0000);
        send_item(OP_DRAW, '0, 32'h8000_0001);
        send_item(OP_SEED, 32'hffff_ffff, '0);
        send_item(OP_DRAW, 32'hffff_ffff, 32'd3);
        send_item(OP_DRAW, '0, 32'd2);
        send_item(OP_DRAW, '0, 32'hc000_0001);
        send_item(OP_DRAW, '0, 32'd0);
        // pause until every result is in
        wait_drained();
    endtask

    task automatic test_wrap();
        // well past the twist point
        send_item(OP_SEED, $urandom(), '0);
        rsp_stall_on = 1'b0;
        for (int k = 0; k < 630; k++) send_item(OP_DRAW, '0, 32'd0);
        rsp_stall_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_unseeded_after_reg(input logic [31:0] v);
        wait_drained();
        write_seed_reg(v);
        send_item(OP_DRAW, '0, $urandom());
    endtask

    task automatic test_random(input int n);
        logic [31:0] b;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0: b = 32'd0;
                1: b = 32'd1 << $urandom_range(0, 31);
                2: b = $urandom_range(1, 100);
                3: b = 32'h8000_0000 + $urandom_range(1, 1000);
                default: b = $urandom();
            endcase
            if ($urandom_range(0, 24) == 0) send_item(OP_SEED, $urandom(), $urandom());
            else send_item(OP_DRAW, $urandom(), b);
        end
        wait_drained();
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        rsp_stall_on = 1'b1;
        seed_reg = DefaultSeed;
        mt_seeded = 1'b0;
        mt_pos = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_default_seed();
        test_directed();
        test_random(100);
        // register is only used while unseeded; hold-off after reset is not possible,
        // so only the first draw of the run saw it. Still write the extreme values 0 and all ones.
        test_unseeded_after_reg(32'd0);
        test_unseeded_after_reg(32'hffff_ffff);
        wait_drained();
        test_wrap();
        test_random(250);
        wait_drained();
        $display("covered %0d draws and %0d reseeds, %0d results checked",
                 draws_sent, seeds_sent, values_checked);
        $display("bounds: zero, one, powers of two, extremes; ring wrap and default seed");
        if (mismatches == 0 && expected_values.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
